// ===== hw/rtl/gts_pkg.sv =====
// ----------------------------------------------------------------------------
// gts_pkg
// Shared constants and types of the trajectory smoother.
// ----------------------------------------------------------------------------
package gts_pkg;

	localparam int MAX_TAPS_DEF   = 7;
	localparam int COORD_BITS_DEF = 24;
	localparam int NUM_WEIGHTS    = 7;
	localparam int NUM_DIMS       = 3;
	localparam int WEIGHT_BITS    = 16;
	localparam int FRAC_BITS      = 15;
	localparam int TAP_BITS       = 3;
	localparam int HALF_BITS      = TAP_BITS - 1;
	localparam int FRAME_BITS     = 3;
	localparam int CFG_IDX_BITS   = 3;

	localparam logic [WEIGHT_BITS-1:0] WEIGHT_ONE = 16'h8000;

	typedef logic [WEIGHT_BITS-1:0] gts_weight_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_TAP_COUNT = 3'd0,
		REG_WEIGHT_0  = 3'd1,
		REG_WEIGHT_1  = 3'd2,
		REG_WEIGHT_2  = 3'd3,
		REG_WEIGHT_3  = 3'd4,
		REG_WEIGHT_4  = 3'd5,
		REG_WEIGHT_5  = 3'd6,
		REG_WEIGHT_6  = 3'd7
	} gts_reg_t;

	// stage load enables handed from the pipeline control to the lanes
	typedef struct packed {
		logic en_s1;
		logic en_s2;
		logic en_s3;
	} gts_adv_t;

endpackage

// ===== hw/rtl/gts_window.sv =====
// ----------------------------------------------------------------------------
// gts_window
// Sample window and frame sequencer: takes input frames, repeats the first
// frame on the left edge, runs the flush of the right edge after a final frame
// and issues one filter job per output frame.
// ----------------------------------------------------------------------------
module gts_window #(
	parameter int MAX_TAPS   = gts_pkg::MAX_TAPS_DEF,
	parameter int COORD_BITS = gts_pkg::COORD_BITS_DEF,
	parameter int WIN_DEPTH  = 2 * (MAX_TAPS / 2) + 1
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [COORD_BITS-1:0]  coord [gts_pkg::NUM_DIMS],
	input  logic                          final_frame,
	input  logic [gts_pkg::HALF_BITS-1:0] half,
	input  logic                          job_take,
	output logic                          job_v,
	output logic                          job_end,
	output logic signed [COORD_BITS-1:0]  win [gts_pkg::NUM_DIMS][WIN_DEPTH]
);
	import gts_pkg::*;

	logic signed [COORD_BITS-1:0] win_q [NUM_DIMS][WIN_DEPTH];
	logic [FRAME_BITS-1:0]        frames_q;
	logic [FRAME_BITS-1:0]        frames_inc;
	logic [HALF_BITS-1:0]         flush_q;
	logic                         job_v_q;
	logic                         job_end_q;
	logic                         slot_free;
	logic                         accept;
	logic                         step;
	logic                         emit_now;

	assign slot_free  = !job_v_q || job_take;
	assign in_ready   = (flush_q == '0) && slot_free;
	assign accept     = in_valid && in_ready;
	assign step       = (flush_q != '0) && slot_free;
	assign frames_inc = (frames_q == '1) ? frames_q : frames_q + 1'b1;
	assign emit_now   = frames_inc > FRAME_BITS'(half);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q  <= '0;
			flush_q   <= '0;
			job_v_q   <= 1'b0;
			job_end_q <= 1'b0;
		end else if (accept) begin
			job_v_q   <= emit_now;
			job_end_q <= final_frame && (half == '0);
			flush_q   <= final_frame ? half : '0;
			frames_q  <= (final_frame && (half == '0)) ? '0 : frames_inc;
		end else if (step) begin
			// right edge: last frame repeated
			job_v_q   <= emit_now;
			job_end_q <= (flush_q == HALF_BITS'(1));
			flush_q   <= flush_q - 1'b1;
			frames_q  <= (flush_q == HALF_BITS'(1)) ? '0 : frames_inc;
		end else if (job_take) begin
			job_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			for (int d = 0; d < NUM_DIMS; d++) begin
				win_q[d][0] <= coord[d];
				for (int a = 1; a < WIN_DEPTH; a++) begin
					win_q[d][a] <= (frames_q == '0) ? coord[d] : win_q[d][a-1];
				end
			end
		end else if (step) begin
			for (int d = 0; d < NUM_DIMS; d++) begin
				for (int a = 1; a < WIN_DEPTH; a++) begin
					win_q[d][a] <= win_q[d][a-1];
				end
			end
		end
	end

	assign job_v   = job_v_q;
	assign job_end = job_end_q;
	assign win     = win_q;

endmodule

// ===== hw/rtl/gts_lane.sv =====
// ----------------------------------------------------------------------------
// gts_lane
// One coordinate of the FIR: tap products, two partial sums, full sum.
// ----------------------------------------------------------------------------
module gts_lane #(
	parameter int MAX_TAPS   = gts_pkg::MAX_TAPS_DEF,
	parameter int COORD_BITS = gts_pkg::COORD_BITS_DEF,
	parameter int WIN_DEPTH  = 2 * (MAX_TAPS / 2) + 1
) (
	input  logic                                            clk,
	input  gts_pkg::gts_adv_t                               adv,
	input  logic [gts_pkg::TAP_BITS-1:0]                    taps,
	input  logic [gts_pkg::HALF_BITS-1:0]                   half,
	input  gts_pkg::gts_weight_t                            weights [gts_pkg::NUM_WEIGHTS],
	input  logic signed [COORD_BITS-1:0]                    win [WIN_DEPTH],
	output logic signed [COORD_BITS+gts_pkg::WEIGHT_BITS+3:0] sum
);
	import gts_pkg::*;

	localparam int PROD_W = COORD_BITS + WEIGHT_BITS + 1;
	localparam int SUM_W  = PROD_W + 3;
	localparam int SPLIT  = (MAX_TAPS + 1) / 2;
	localparam int AGE_W  = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1;

	logic signed [PROD_W-1:0] prod_d  [MAX_TAPS];
	logic signed [PROD_W-1:0] prod_s1 [MAX_TAPS];
	logic signed [SUM_W-1:0]  lo_d;
	logic signed [SUM_W-1:0]  hi_d;
	logic signed [SUM_W-1:0]  lo_s2;
	logic signed [SUM_W-1:0]  hi_s2;
	logic signed [SUM_W-1:0]  sum_s3;

	// tap k reads the sample of age 2*half - k
	always_comb begin
		int                       age;
		logic signed [COORD_BITS-1:0] smp;
		logic signed [PROD_W-1:0] wt;
		logic signed [PROD_W-1:0] sx;
		for (int k = 0; k < MAX_TAPS; k++) begin
			age = 2 * int'(half) - k;
			smp = '0;
			if (k < int'(taps) && age >= 0 && age < WIN_DEPTH) begin
				smp = win[AGE_W'(age)];
			end
			wt = {{(PROD_W-WEIGHT_BITS){1'b0}}, weights[k]};
			sx = {{(PROD_W-COORD_BITS){smp[COORD_BITS-1]}}, smp};
			prod_d[k] = wt * sx;
		end
	end

	always_comb begin
		lo_d = '0;
		hi_d = '0;
		for (int k = 0; k < MAX_TAPS; k++) begin
			if (k < SPLIT) begin
				lo_d = lo_d + SUM_W'(prod_s1[k]);
			end else begin
				hi_d = hi_d + SUM_W'(prod_s1[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv.en_s1) begin
			prod_s1 <= prod_d;
		end
		if (adv.en_s2) begin
			lo_s2 <= lo_d;
			hi_s2 <= hi_d;
		end
		if (adv.en_s3) begin
			sum_s3 <= lo_s2 + hi_s2;
		end
	end

	assign sum = sum_s3;

endmodule

// ===== hw/rtl/gts_merge.sv =====
// ----------------------------------------------------------------------------
// gts_merge
// Output stage: rounds and saturates the three lane sums into one result
// register with its valid flag.
// ----------------------------------------------------------------------------
module gts_merge #(
	parameter int COORD_BITS = gts_pkg::COORD_BITS_DEF
) (
	input  logic                                            clk,
	input  logic                                            arst_n,
	input  logic                                            v_s3,
	input  logic                                            end_s3,
	input  logic signed [COORD_BITS+gts_pkg::WEIGHT_BITS+3:0] sum [gts_pkg::NUM_DIMS],
	output logic                                            rdy_out,
	output logic                                            out_valid,
	input  logic                                            out_ready,
	output logic signed [COORD_BITS-1:0]                    smooth_x,
	output logic signed [COORD_BITS-1:0]                    smooth_y,
	output logic signed [COORD_BITS-1:0]                    smooth_z,
	output logic                                            end_of_run
);
	import gts_pkg::*;

	localparam int SUM_W = COORD_BITS + WEIGHT_BITS + 4;
	localparam int HALF_LSB = 1 << (FRAC_BITS - 1);
	localparam logic signed [SUM_W-1:0] SAT_HI =
		{{(SUM_W-COORD_BITS+1){1'b0}}, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [SUM_W-1:0] SAT_LO =
		{{(SUM_W-COORD_BITS+1){1'b1}}, {(COORD_BITS-1){1'b0}}};
	localparam logic signed [COORD_BITS-1:0] COORD_MAX = {1'b0, {(COORD_BITS-1){1'b1}}};
	localparam logic signed [COORD_BITS-1:0] COORD_MIN = {1'b1, {(COORD_BITS-1){1'b0}}};

	logic                         out_valid_q;
	logic signed [COORD_BITS-1:0] res_q [NUM_DIMS];
	logic                         end_q;

	// round half up, then clamp
	function automatic logic signed [COORD_BITS-1:0] round_sat(
		input logic signed [SUM_W-1:0] s
	);
		logic signed [SUM_W-1:0] r;
		r = (s + SUM_W'(HALF_LSB)) >>> FRAC_BITS;
		if (r > SAT_HI) begin
			return COORD_MAX;
		end else if (r < SAT_LO) begin
			return COORD_MIN;
		end
		return r[COORD_BITS-1:0];
	endfunction

	assign rdy_out = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (rdy_out) begin
			out_valid_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_out) begin
			for (int d = 0; d < NUM_DIMS; d++) begin
				res_q[d] <= round_sat(sum[d]);
			end
			end_q <= end_s3;
		end
	end

	assign out_valid  = out_valid_q;
	assign smooth_x   = res_q[0];
	assign smooth_y   = res_q[1];
	assign smooth_z   = res_q[2];
	assign end_of_run = end_q;

endmodule

// ===== hw/rtl/gaussian_trajectory_smoother_unit.sv =====
// ----------------------------------------------------------------------------
// gaussian_trajectory_smoother_unit
// Weighted FIR smoothing of a 3D trajectory, one frame per transfer. Results
// lag the input by tap_count/2 frames, edges repeat the first and last frame,
// and each output is rounded to nearest and saturated. An input frame is taken
// every cycle while the output side keeps up; a frame marked final holds off
// input while the flush sequencer in the window stage shifts in tap_count/2
// repeats of the last frame. The window and job register load at the input
// transfer; output valid then passes through the registered tap products,
// partial sums, full sum and rounded output register. Three coordinate lanes
// run side by side. Configuration writes take effect at once and are expected
// while idle.
// ----------------------------------------------------------------------------
module gaussian_trajectory_smoother_unit #(
	parameter int MAX_TAPS   = gts_pkg::MAX_TAPS_DEF,
	parameter int COORD_BITS = gts_pkg::COORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [COORD_BITS-1:0]        coord_x,
	input  logic signed [COORD_BITS-1:0]        coord_y,
	input  logic signed [COORD_BITS-1:0]        coord_z,
	input  logic                                final_frame,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [COORD_BITS-1:0]        smooth_x,
	output logic signed [COORD_BITS-1:0]        smooth_y,
	output logic signed [COORD_BITS-1:0]        smooth_z,
	output logic                                end_of_run,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [gts_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  logic [gts_pkg::WEIGHT_BITS-1:0]     cfg_data
);
	import gts_pkg::*;

	localparam int WIN_DEPTH = 2 * (MAX_TAPS / 2) + 1;
	localparam int SUM_W     = COORD_BITS + WEIGHT_BITS + 4;

	logic [TAP_BITS-1:0]          tap_q;
	gts_weight_t                  weight_q [NUM_WEIGHTS];
	logic [CFG_IDX_BITS-1:0]      wsel;
	logic [TAP_BITS-1:0]          taps;
	logic [HALF_BITS-1:0]         half;

	logic signed [COORD_BITS-1:0] coord [NUM_DIMS];
	logic signed [COORD_BITS-1:0] win [NUM_DIMS][WIN_DEPTH];
	logic signed [SUM_W-1:0]      sum [NUM_DIMS];
	logic                         job_v;
	logic                         job_end;
	logic                         job_take;

	logic                         v_s1, v_s2, v_s3;
	logic                         end_s1, end_s2, end_s3;
	logic                         rdy1, rdy2, rdy3, rdy_out;
	gts_adv_t                     adv;

	// configuration registers
	assign cfg_ready = 1'b1;
	assign wsel      = cfg_index - CFG_IDX_BITS'(REG_WEIGHT_0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= TAP_BITS'(1);
			for (int i = 0; i < NUM_WEIGHTS; i++) begin
				weight_q[i] <= (i == 0) ? WEIGHT_ONE : '0;
			end
		end else if (cfg_valid) begin
			if (cfg_index == REG_TAP_COUNT) begin
				tap_q <= cfg_data[TAP_BITS-1:0];
			end else begin
				weight_q[wsel] <= cfg_data;
			end
		end
	end

	// zero taps act as one, too many as MAX_TAPS
	always_comb begin
		if (tap_q == '0) begin
			taps = TAP_BITS'(1);
		end else if (int'(tap_q) > MAX_TAPS) begin
			taps = TAP_BITS'(MAX_TAPS);
		end else begin
			taps = tap_q;
		end
	end
	assign half = taps[TAP_BITS-1:1];

	assign coord[0] = coord_x;
	assign coord[1] = coord_y;
	assign coord[2] = coord_z;

	gts_window #(
		.MAX_TAPS   (MAX_TAPS),
		.COORD_BITS (COORD_BITS),
		.WIN_DEPTH  (WIN_DEPTH)
	) u_window (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.coord       (coord),
		.final_frame (final_frame),
		.half        (half),
		.job_take    (job_take),
		.job_v       (job_v),
		.job_end     (job_end),
		.win         (win)
	);

	// pipeline control, bubbles collapse
	assign rdy3     = !v_s3 || rdy_out;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign job_take = job_v && rdy1;
	assign adv      = '{en_s1: rdy1, en_s2: rdy2, en_s3: rdy3};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= job_v;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			end_s1 <= job_end;
		end
		if (rdy2) begin
			end_s2 <= end_s1;
		end
		if (rdy3) begin
			end_s3 <= end_s2;
		end
	end

	for (genvar d = 0; d < NUM_DIMS; d++) begin : g_lane
		gts_lane #(
			.MAX_TAPS   (MAX_TAPS),
			.COORD_BITS (COORD_BITS),
			.WIN_DEPTH  (WIN_DEPTH)
		) u_lane (
			.clk     (clk),
			.adv     (adv),
			.taps    (taps),
			.half    (half),
			.weights (weight_q),
			.win     (win[d]),
			.sum     (sum[d])
		);
	end

	gts_merge #(
		.COORD_BITS (COORD_BITS)
	) u_merge (
		.clk        (clk),
		.arst_n     (arst_n),
		.v_s3       (v_s3),
		.end_s3     (end_s3),
		.sum        (sum),
		.rdy_out    (rdy_out),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.smooth_x   (smooth_x),
		.smooth_y   (smooth_y),
		.smooth_z   (smooth_z),
		.end_of_run (end_of_run)
	);

`ifndef SYNTHESIS
	// a final frame with a nonzero half window must stall input for the flush
	a_flush_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && final_frame && (half != '0)) |=> !in_ready)
		else $error("input taken during flush");

	// a pending job is not dropped while stage one is blocked
	a_job_held: assert property (@(posedge clk) disable iff (!arst_n)
		(job_v && !rdy1) |=> job_v)
		else $error("filter job lost");

	// a blocked sum stage keeps its item and end flag
	a_s3_held: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s3 && !rdy3) |=> (v_s3 && $stable(end_s3)))
		else $error("sum stage changed while stalled");
`endif

endmodule
